>>> hdl/lrukv_pkg.sv
// Shared constants and types of the LRU key-value cache.
package lrukv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic capture;
		logic commit;
	} lrukv_cmd_t;

endpackage

>>> hdl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// Each input beat is captured into the input registers; at the commit all keys are
// compared, the recency ranks are updated and the result is registered. A stalled
// output beat holds the commit; no new beat is accepted until the last one commits.
// Reset clears valid bits, ranks and occupancy at once and sets capacity to 16;
// key and value storage is not cleared and no clearing pass runs.
module lru_key_value_cache_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [lrukv_pkg::CAP_W-1:0]          cfg_write_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic signed [lrukv_pkg::KEY_W-1:0]   lookup_key,
	input  logic signed [lrukv_pkg::VAL_W-1:0]   write_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic signed [lrukv_pkg::VAL_W-1:0]   read_value,
	output logic                                 evicted,
	output logic signed [lrukv_pkg::KEY_W-1:0]   evicted_key
);
	import lrukv_pkg::*;

	lrukv_cmd_t cmd;

	lrukv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lrukv_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.action         (action),
		.lookup_key     (lookup_key),
		.write_value    (write_value),
		.hit            (hit),
		.read_value     (read_value),
		.evicted        (evicted),
		.evicted_key    (evicted_key)
	);

endmodule

>>> hdl/lrukv_ctrl.sv
// Sequencer of the cache: accepts a beat, commits it, holds the output beat.
module lrukv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output lrukv_pkg::lrukv_cmd_t cmd
);
	import lrukv_pkg::*;

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = (state_q == IDLE) && in_valid;
		cmd.commit  = (state_q == EXEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_valid)
						state_q <= EXEC;
				end
				EXEC: begin
					// hold until the output register can take the result
					if (out_free)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> hdl/lrukv_datapath.sv
// Entry storage, parallel key compare, recency ranks and output register.
module lrukv_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lrukv_pkg::lrukv_cmd_t                cmd,
	input  logic                                 cfg_write_en,
	input  logic [lrukv_pkg::CAP_W-1:0]          cfg_write_data,
	input  logic                                 action,
	input  logic signed [lrukv_pkg::KEY_W-1:0]   lookup_key,
	input  logic signed [lrukv_pkg::VAL_W-1:0]   write_value,
	output logic                                 hit,
	output logic signed [lrukv_pkg::VAL_W-1:0]   read_value,
	output logic                                 evicted,
	output logic signed [lrukv_pkg::KEY_W-1:0]   evicted_key
);
	import lrukv_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [OCC_W-1:0]  occ_q;
	logic [ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0] rank_q [ENTRIES];
	logic [KEY_W-1:0]  key_mem_q [ENTRIES];
	logic [VAL_W-1:0]  val_mem_q [ENTRIES];

	logic              action_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  wval_q;

	logic              hit_q;
	logic [VAL_W-1:0]  rdata_q;
	logic              evict_q;
	logic [KEY_W-1:0]  evkey_q;

	logic [OCC_W-1:0]  cap_eff;
	logic [ENTRIES-1:0] hit_vec, old_vec, free_oh;
	logic [IDX_W-1:0]  hit_idx, old_idx, free_idx, tgt_idx;
	logic              any_hit, do_put, has_room, ins_free, ins_evict, touch;
	logic [RANK_W-1:0] oldest_rank, tgt_rank;

	always_comb begin
		if (32'(cap_q) > 32'(ENTRIES))
			cap_eff = OCC_W'(ENTRIES);
		else
			cap_eff = OCC_W'(cap_q);
	end

	assign oldest_rank = RANK_W'(occ_q - OCC_W'(1));
	// lowest invalid entry as a one-hot
	assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

	always_comb begin
		hit_idx  = '0;
		old_idx  = '0;
		free_idx = '0;
		for (int j = 0; j < ENTRIES; j++) begin
			hit_vec[j] = valid_q[j] && (key_mem_q[j] == key_q);
			old_vec[j] = valid_q[j] && (rank_q[j] == oldest_rank);
			if (hit_vec[j])
				hit_idx = hit_idx | IDX_W'(j);
			if (old_vec[j])
				old_idx = old_idx | IDX_W'(j);
			if (free_oh[j])
				free_idx = free_idx | IDX_W'(j);
		end
	end

	assign any_hit   = |hit_vec;
	assign do_put    = (action_q == ACT_PUT) && (cap_eff != '0);
	assign has_room  = occ_q < cap_eff;
	assign ins_free  = do_put && !any_hit && has_room;
	assign ins_evict = do_put && !any_hit && !has_room;
	assign touch     = do_put || ((action_q == ACT_GET) && any_hit);
	assign tgt_rank  = rank_q[tgt_idx];

	always_comb begin
		priority if (any_hit)
			tgt_idx = hit_idx;
		else if (ins_free)
			tgt_idx = free_idx;
		else
			tgt_idx = old_idx;
	end

	// capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			key_q    <= lookup_key;
			wval_q   <= write_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write_en) begin
			cap_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			valid_q <= '0;
			for (int j = 0; j < ENTRIES; j++)
				rank_q[j] <= '0;
		end else if (cmd.commit && touch) begin
			if (ins_free) begin
				occ_q            <= occ_q + OCC_W'(1);
				valid_q[tgt_idx] <= 1'b1;
			end
			// age every entry more recent than the target; a fresh slot ages all
			for (int j = 0; j < ENTRIES; j++) begin
				if (IDX_W'(j) == tgt_idx)
					rank_q[j] <= '0;
				else if (valid_q[j] && (ins_free || (rank_q[j] < tgt_rank)))
					rank_q[j] <= rank_q[j] + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_put) begin
			val_mem_q[tgt_idx] <= wval_q;
			if (!any_hit)
				key_mem_q[tgt_idx] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q   <= any_hit && ((action_q == ACT_GET) || do_put);
			rdata_q <= ((action_q == ACT_GET) && any_hit) ? val_mem_q[hit_idx] : '0;
			evict_q <= ins_evict;
			evkey_q <= ins_evict ? key_mem_q[old_idx] : '0;
		end
	end

	assign hit         = hit_q;
	assign read_value  = rdata_q;
	assign evicted     = evict_q;
	assign evicted_key = evkey_q;

endmodule
